// ===== sv/sdg_pkg.sv =====
`default_nettype none
package sdg_pkg;

  // Event codes
  localparam logic [2:0] CMD_BEGIN      = 3'd0;
  localparam logic [2:0] CMD_STARTED    = 3'd1;
  localparam logic [2:0] CMD_DONE       = 3'd2;
  localparam logic [2:0] CMD_TIMEOUT    = 3'd3;
  localparam logic [2:0] CMD_DISCONNECT = 3'd4;
  localparam logic [2:0] CMD_TICK       = 3'd5;

  // Phase codes
  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_PREPARING    = 3'd1;
  localparam logic [2:0] PH_SUSPENDED    = 3'd2;
  localparam logic [2:0] PH_SCANNING     = 3'd3;
  localparam logic [2:0] PH_COLLECTING   = 3'd4;
  localparam logic [2:0] PH_RESTORING    = 3'd5;
  localparam logic [2:0] PH_ERROR        = 3'd6;
  localparam logic [2:0] PH_DISCONNECTED = 3'd7;

  localparam int unsigned LIMIT_BITS = 32;
  localparam int unsigned NOW_BITS   = 32;

  typedef struct packed {
    logic [2:0]          command;
    logic                event_ok;
    logic                suspend_granted;
    logic [NOW_BITS-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       begin_accepted;
    logic       resume_display;
    logic [2:0] phase;
    logic       display_suspended;
  } out_item_t;

  // Phase and suspend flag of the guard
  typedef struct packed {
    logic [2:0] phase;
    logic       suspended;
  } guard_state_t;

endpackage
`default_nettype wire

// ===== sv/scan_display_guard_fsm.sv =====
`default_nettype none
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    sdg_pkg::in_item_t  (in_data)
// out_     output     out_valid / out_ready  sdg_pkg::out_item_t (out_data)
// cfg_     input      cfg_we (no wait)       timeout limit, ms   (cfg_wdata)
//
// One event per cycle sustained while out_ready takes results. An event is held
// in the input register; the guard state and the result register update together
// when it advances, and out_valid then rises from the result register. in_ready
// stays high while the result register is empty or being taken. Synchronous reset
// returns to idle, not suspended, window unanchored, limit zero.
module scan_display_guard_fsm #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire sdg_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output sdg_pkg::out_item_t                    out_data,
  input  wire                                   cfg_we,
  input  wire logic [sdg_pkg::LIMIT_BITS-1:0]   cfg_wdata
);

  // time is narrowed to the smaller of the field width and TIME_BITS
  localparam int unsigned TW = (TIME_BITS < sdg_pkg::NOW_BITS) ? TIME_BITS
                                                               : sdg_pkg::NOW_BITS;

  logic                            in_valid_r;
  sdg_pkg::in_item_t               in_data_r;
  logic                            out_valid_r;
  sdg_pkg::out_item_t              out_data_r;
  sdg_pkg::guard_state_t           st_r;
  sdg_pkg::guard_state_t           st_nxt;
  logic [TW-1:0]                   win_r;
  logic [TW-1:0]                   win_nxt;
  logic [sdg_pkg::LIMIT_BITS-1:0]  limit_r;
  sdg_pkg::out_item_t              res;
  logic                            advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  sdg_step #(
    .TW (TW)
  ) u_step (
    .item    (in_data_r),
    .st      (st_r),
    .win     (win_r),
    .limit   (limit_r),
    .st_nxt  (st_nxt),
    .win_nxt (win_nxt),
    .res     (res)
  );

  // guard state, committed when the event moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{phase: sdg_pkg::PH_IDLE, suspended: 1'b0};
      win_r <= '0;
    end else if (advance) begin
      st_r  <= st_nxt;
      win_r <= win_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  // resume pulse always leaves the display released
  a_resume_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.resume_display) |-> !out_data_r.display_suspended)
    else $error("resume issued while display still suspended");

  // accepted begin lands in preparing with the display held
  a_begin_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.begin_accepted) |->
      (out_data_r.display_suspended && (out_data_r.phase == sdg_pkg::PH_PREPARING)))
    else $error("accepted begin without suspended preparing phase");

  // window anchor only lives inside the scan window
  a_win_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (win_r != '0) |-> ((st_r.phase == sdg_pkg::PH_SUSPENDED) ||
                       (st_r.phase == sdg_pkg::PH_SCANNING) ||
                       (st_r.phase == sdg_pkg::PH_COLLECTING)))
    else $error("window anchored outside scan window");

  // display is only held suspended during a session
  a_susp_session: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.suspended |-> ((st_r.phase == sdg_pkg::PH_PREPARING) ||
                        (st_r.phase == sdg_pkg::PH_SUSPENDED) ||
                        (st_r.phase == sdg_pkg::PH_SCANNING) ||
                        (st_r.phase == sdg_pkg::PH_COLLECTING)))
    else $error("display suspended outside a session");

endmodule
`default_nettype wire

// ===== sv/sdg_step.sv =====
`default_nettype none
// Next-state and result logic for one event.
module sdg_step #(
  parameter int unsigned TW = 32
) (
  input  wire sdg_pkg::in_item_t               item,
  input  wire sdg_pkg::guard_state_t           st,
  input  wire logic [TW-1:0]                   win,
  input  wire logic [sdg_pkg::LIMIT_BITS-1:0]  limit,
  output sdg_pkg::guard_state_t                st_nxt,
  output logic [TW-1:0]                        win_nxt,
  output sdg_pkg::out_item_t                   res
);

  logic [TW-1:0] now_t;
  logic [TW-1:0] elapsed;
  logic          terminal;
  logic          in_window;
  logic          in_session;
  logic          accepted;
  logic          resume;
  logic          expired;

  assign now_t   = item.now_ms[TW-1:0];
  assign elapsed = now_t - win;

  assign terminal   = (st.phase == sdg_pkg::PH_IDLE) || (st.phase == sdg_pkg::PH_ERROR) ||
                      (st.phase == sdg_pkg::PH_DISCONNECTED);
  assign in_window  = (st.phase == sdg_pkg::PH_SUSPENDED) ||
                      (st.phase == sdg_pkg::PH_SCANNING) ||
                      (st.phase == sdg_pkg::PH_COLLECTING);
  assign in_session = (st.phase == sdg_pkg::PH_PREPARING) || in_window;

  // anchored window, clock not backwards, limit reached
  assign expired = (win != '0) && (now_t >= win) &&
                   (sdg_pkg::LIMIT_BITS'(elapsed) >= limit);

  always_comb begin
    st_nxt   = st;
    win_nxt  = win;
    accepted = 1'b0;
    resume   = 1'b0;
    unique case (item.command)
      sdg_pkg::CMD_BEGIN: begin
        if (terminal) begin
          win_nxt = '0;
          if (item.suspend_granted) begin
            st_nxt.phase     = sdg_pkg::PH_PREPARING;
            st_nxt.suspended = 1'b1;
            accepted         = 1'b1;
          end else begin
            st_nxt.phase     = sdg_pkg::PH_ERROR;
            st_nxt.suspended = 1'b0;
          end
        end
      end
      sdg_pkg::CMD_STARTED: begin
        if (st.phase == sdg_pkg::PH_PREPARING) begin
          win_nxt = '0;
          if (item.event_ok) begin
            st_nxt.phase = sdg_pkg::PH_SUSPENDED;
          end else begin
            st_nxt.phase     = sdg_pkg::PH_ERROR;
            st_nxt.suspended = 1'b0;
            resume           = st.suspended;
          end
        end
      end
      sdg_pkg::CMD_DONE: begin
        if ((st.phase == sdg_pkg::PH_SUSPENDED) || (st.phase == sdg_pkg::PH_SCANNING)) begin
          win_nxt          = '0;
          st_nxt.phase     = item.event_ok ? sdg_pkg::PH_IDLE : sdg_pkg::PH_ERROR;
          st_nxt.suspended = 1'b0;
          resume           = st.suspended;
        end
      end
      sdg_pkg::CMD_TIMEOUT: begin
        if (in_session) begin
          win_nxt          = '0;
          st_nxt.phase     = sdg_pkg::PH_ERROR;
          st_nxt.suspended = 1'b0;
          resume           = st.suspended;
        end
      end
      sdg_pkg::CMD_DISCONNECT: begin
        win_nxt          = '0;
        st_nxt.phase     = sdg_pkg::PH_DISCONNECTED;
        st_nxt.suspended = 1'b0;
        resume           = st.suspended;
      end
      sdg_pkg::CMD_TICK: begin
        if (in_window && (limit != '0)) begin
          if (win == '0) begin
            win_nxt = now_t;
          end else if (expired) begin
            win_nxt          = '0;
            st_nxt.phase     = sdg_pkg::PH_ERROR;
            st_nxt.suspended = 1'b0;
            resume           = st.suspended;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res.begin_accepted    = accepted;
  assign res.resume_display    = resume;
  assign res.phase             = st_nxt.phase;
  assign res.display_suspended = st_nxt.suspended;

endmodule
`default_nettype wire
